/* src/hvn_pkg.sv */
// Shared types and fixed-point widths for the heightmap vertex-normal stream.
// No dependencies; every other file refers to it by scoped names.
package hvn_pkg;

   localparam int H_W      = 8;    // height byte
   localparam int CFG_W    = 11;   // grid size register
   localparam int POS_W    = 10;   // row and column on the result channel
   localparam int TRI_BITS = 24;   // fraction bits of a triangle unit normal

   localparam int VEC_W  = 28;     // signed vector component into the normaliser
   localparam int MAG_W  = 27;     // magnitude of a component before scaling
   localparam int MS_W   = 31;     // magnitude after the power-of-two scaling
   localparam int SQR_W  = 60;     // sum of squares, scaled to [2^58, 2^60)
   localparam int ROOT_W = 30;     // integer square root of the scaled sum
   localparam int SRM_W  = 34;     // square-root partial remainder
   localparam int QB     = 26;     // quotient bits produced by the divider
   localparam int NUM_W  = 56;     // dividend: scaled magnitude, fraction, rounding
   localparam int RES_W  = QB + 1; // signed normaliser result

   localparam logic [CFG_W-1:0] GRID_RESET = 11'd1024;
   localparam logic [7:0]       Y_RAW      = 8'd255;

   typedef logic signed [VEC_W-1:0] comp_type;
   typedef logic signed [RES_W-1:0] res_type;

   typedef struct packed {
      logic start;
      logic vert_mode;
   } unit_ctl_type;

endpackage

/* src/hvn_unitize.sv */
// Iterative vector normaliser: squares, scales, takes the square root and divides
// one bit a cycle. Uses hvn_pkg for widths and types.
module hvn_unitize #(
   parameter int VERT_BITS = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hvn_pkg::unit_ctl_type ctl,
   input  hvn_pkg::comp_type    vec [3],
   output logic                 done,
   output hvn_pkg::res_type     res [3]
);

   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_SQ   = 3'd1;
   localparam logic [2:0] U_NORM = 3'd2;
   localparam logic [2:0] U_ROOT = 3'd3;
   localparam logic [2:0] U_DPRE = 3'd4;
   localparam logic [2:0] U_DIV  = 3'd5;
   localparam logic [2:0] U_DONE = 3'd6;

   logic [2:0]                    st_ff, st_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic                          mode_ff, mode_in;
   logic [2:0]                    neg_ff, neg_in;
   logic [hvn_pkg::MS_W-1:0]      mag_ff [3];
   logic [hvn_pkg::MS_W-1:0]      mag_in [3];
   logic [hvn_pkg::SQR_W-1:0]     sum_ff, sum_in;
   logic [hvn_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [hvn_pkg::SRM_W-1:0]     srem_ff, srem_in;
   logic [hvn_pkg::ROOT_W-1:0]    drem_ff [3];
   logic [hvn_pkg::ROOT_W-1:0]    drem_in [3];
   logic [hvn_pkg::QB-1:0]        nlo_ff [3];
   logic [hvn_pkg::QB-1:0]        nlo_in [3];
   logic [hvn_pkg::QB-1:0]        quo_ff [3];
   logic [hvn_pkg::QB-1:0]        quo_in [3];
   hvn_pkg::res_type              res_ff [3];
   hvn_pkg::res_type              res_in [3];
   logic                          done_ff, done_in;

   logic [hvn_pkg::MAG_W-1:0]     sq_op;
   logic [2*hvn_pkg::MAG_W-1:0]   prod;
   logic [hvn_pkg::SQR_W-1:0]     sum_add;
   logic [hvn_pkg::SRM_W-1:0]     rem_t, trial;
   logic [hvn_pkg::NUM_W-1:0]     num [3];
   logic [hvn_pkg::ROOT_W:0]      dt [3];
   logic [hvn_pkg::ROOT_W:0]      dd [3];
   logic [2:0]                    ge;
   logic [hvn_pkg::VEC_W-1:0]     absv [3];

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_op = mag_ff[0][hvn_pkg::MAG_W-1:0];
         2'd1:    sq_op = mag_ff[1][hvn_pkg::MAG_W-1:0];
         default: sq_op = mag_ff[2][hvn_pkg::MAG_W-1:0];
      endcase
      prod    = sq_op * sq_op;
      sum_add = sum_ff + hvn_pkg::SQR_W'(prod);
      rem_t   = {srem_ff[hvn_pkg::SRM_W-3:0], sum_ff[hvn_pkg::SQR_W-1 -: 2]};
      trial   = hvn_pkg::SRM_W'({root_ff, 2'b01});
      for (int i = 0; i < 3; i++) begin
         absv[i] = vec[i][hvn_pkg::VEC_W-1] ? -vec[i] : vec[i];
         if (mode_ff) begin
            num[i] = (hvn_pkg::NUM_W'(mag_ff[i]) << VERT_BITS) + hvn_pkg::NUM_W'(root_ff >> 1);
         end else begin
            num[i] = (hvn_pkg::NUM_W'(mag_ff[i]) << hvn_pkg::TRI_BITS)
                   + hvn_pkg::NUM_W'(root_ff >> 1);
         end
         dt[i] = {drem_ff[i], nlo_ff[i][hvn_pkg::QB-1]};
         dd[i] = dt[i] - {1'b0, root_ff};
         ge[i] = dt[i] >= {1'b0, root_ff};
      end
   end

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      neg_in  = neg_ff;
      sum_in  = sum_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      done_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag_in[i]  = mag_ff[i];
         drem_in[i] = drem_ff[i];
         nlo_in[i]  = nlo_ff[i];
         quo_in[i]  = quo_ff[i];
         res_in[i]  = res_ff[i];
      end
      case (st_ff)
         U_IDLE: begin
            if (ctl.start) begin
               mode_in = ctl.vert_mode;
               sum_in  = '0;
               cnt_in  = '0;
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vec[i][hvn_pkg::VEC_W-1];
                  mag_in[i] = hvn_pkg::MS_W'(absv[i][hvn_pkg::MAG_W-1:0]);
               end
               st_in = U_SQ;
            end
         end
         U_SQ: begin
            sum_in = sum_add;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd2) begin
               cnt_in = '0;
               if (sum_add == '0) begin
                  // zero-length vector: result is zero
                  for (int i = 0; i < 3; i++) quo_in[i] = '0;
                  st_in = U_DONE;
               end else begin
                  st_in = U_NORM;
               end
            end
         end
         U_NORM: begin
            if (sum_ff[hvn_pkg::SQR_W-1 -: 2] == 2'b00) begin
               sum_in = sum_ff << 2;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               root_in = '0;
               srem_in = '0;
               cnt_in  = '0;
               st_in   = U_ROOT;
            end
         end
         U_ROOT: begin
            sum_in = sum_ff << 2;
            if (rem_t >= trial) begin
               srem_in = rem_t - trial;
               root_in = {root_ff[hvn_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = rem_t;
               root_in = {root_ff[hvn_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(hvn_pkg::ROOT_W - 1)) st_in = U_DPRE;
         end
         U_DPRE: begin
            for (int i = 0; i < 3; i++) begin
               drem_in[i] = num[i][hvn_pkg::NUM_W-1 -: hvn_pkg::ROOT_W];
               nlo_in[i]  = num[i][hvn_pkg::QB-1:0];
               quo_in[i]  = '0;
            end
            cnt_in = '0;
            st_in  = U_DIV;
         end
         U_DIV: begin
            for (int i = 0; i < 3; i++) begin
               drem_in[i] = ge[i] ? dd[i][hvn_pkg::ROOT_W-1:0] : dt[i][hvn_pkg::ROOT_W-1:0];
               nlo_in[i]  = nlo_ff[i] << 1;
               quo_in[i]  = {quo_ff[i][hvn_pkg::QB-2:0], ge[i]};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(hvn_pkg::QB - 1)) st_in = U_DONE;
         end
         U_DONE: begin
            for (int i = 0; i < 3; i++) begin
               res_in[i] = neg_ff[i] ? -$signed({1'b0, quo_ff[i]}) : $signed({1'b0, quo_ff[i]});
            end
            done_in = 1'b1;
            st_in   = U_IDLE;
         end
         default: st_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      neg_ff  <= neg_in;
      sum_ff  <= sum_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      for (int i = 0; i < 3; i++) begin
         mag_ff[i]  <= mag_in[i];
         drem_ff[i] <= drem_in[i];
         nlo_ff[i]  <= nlo_in[i];
         quo_ff[i]  <= quo_in[i];
         res_ff[i]  <= res_in[i];
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

/* src/heightmap_vertex_normal_stream.sv */
// Heightmap vertex normals: accepts one height item when idle, then emits 0 to 4 vertices.
// Each vertex: a buffer fetch, 6 triangle slots and up to 7 normaliser passes, each of which
// scales by power-of-two shifts and lets root and divider resolve one bit a cycle.
// An item that emits nothing leaves the block idle for the next one. Results leave
// through a registered output stage.
// Synchronous active-high reset clears control state; the line store is not cleared.
module heightmap_vertex_normal_stream #(
   parameter int MAX_GRID         = 1024,
   parameter int NORMAL_FRAC_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [hvn_pkg::CFG_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hvn_pkg::H_W-1:0]           req_height_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hvn_pkg::POS_W-1:0]         rsp_vertex_row,
   output logic [hvn_pkg::POS_W-1:0]         rsp_vertex_col,
   output logic [hvn_pkg::H_W-1:0]           rsp_vertex_height,
   output logic signed [NORMAL_FRAC_BITS:0]  rsp_normal_x,
   output logic [NORMAL_FRAC_BITS-1:0]       rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS:0]  rsp_normal_z,
   output logic                              rsp_last_vertex
);

   localparam int CW = $clog2(MAX_GRID);
   localparam int SW = $clog2(MAX_GRID + 1);
   localparam int AW = $clog2(3 * MAX_GRID);
   localparam int LIM = (1 << NORMAL_FRAC_BITS) - 1;

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_FETCH = 3'd1;
   localparam logic [2:0] T_TRI   = 3'd2;
   localparam logic [2:0] T_TWAIT = 3'd3;
   localparam logic [2:0] T_VERT  = 3'd4;
   localparam logic [2:0] T_VWAIT = 3'd5;
   localparam logic [2:0] T_OUT   = 3'd6;

   // Three line buffers in one store; row r lives in line r mod 3.
   logic [hvn_pkg::H_W-1:0] mem [3*MAX_GRID];
   logic [hvn_pkg::H_W-1:0] rd_data_ff;
   logic [AW-1:0]           waddr, raddr;
   logic                    rd_en;

   logic [2:0]               st_ff, st_in;
   logic [hvn_pkg::CFG_W-1:0] grid_ff, grid_in;
   logic [CW-1:0]            in_row_ff, in_row_in, in_col_ff, in_col_in;
   logic [1:0]               in_line_ff, in_line_in;
   logic [CW-1:0]            r_ff, r_in, c_ff, c_in;
   logic [1:0]               line_ff, line_in;
   logic [3:0]               em_ff, em_in;
   logic [3:0]               fcnt_ff, fcnt_in;
   logic [1:0]               fr_ff, fr_in, fc_ff, fc_in;
   logic [hvn_pkg::H_W-1:0]  hs_ff [9];
   logic [2:0]               tri_ff, tri_in;
   hvn_pkg::comp_type        acc_ff [3];
   hvn_pkg::comp_type        acc_in [3];
   hvn_pkg::res_type         nrm_ff [3];
   hvn_pkg::res_type         nrm_in [3];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hvn_pkg::POS_W-1:0]     row_ff, col_ff;
   logic [hvn_pkg::H_W-1:0]       hgt_ff;
   logic [NORMAL_FRAC_BITS:0]     nx_ff, nz_ff;
   logic [NORMAL_FRAC_BITS-1:0]   ny_ff;
   logic                          last_ff;

   logic                     accept, load;
   logic [SW-1:0]            eff_s;
   logic [CW-1:0]            smax;
   logic [3:0]               em_new, em_low;
   logic [CW-1:0]            vz, vx;
   logic                     z_is_r;
   logic [1:0]               ln0, fline;
   logic [CW:0]              csum;
   logic [CW-1:0]            fcol;
   logic [5:0]               tri_en;
   logic [hvn_pkg::H_W-1:0]  tp, tq, tp2, tq2;
   logic signed [hvn_pkg::H_W:0] d1, d2;
   logic signed [SW+hvn_pkg::H_W+1:0] m1, m2;
   hvn_pkg::unit_ctl_type    u_ctl;
   hvn_pkg::comp_type        u_vec [3];
   logic                     u_done;
   hvn_pkg::res_type         u_res [3];
   hvn_pkg::res_type         sat [3];

   function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] s;
      s = {1'b0, a} + {1'b0, b};
      add_mod3 = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   // Effective grid size: clamp the register into 2 .. MAX_GRID.
   always_comb begin
      if (grid_ff < 2) begin
         eff_s = SW'(2);
      end else if (32'(grid_ff) > MAX_GRID) begin
         eff_s = SW'(MAX_GRID);
      end else begin
         eff_s = SW'(grid_ff);
      end
      smax = CW'(eff_s - SW'(1));
   end

   assign req_stall = (st_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;

   // Vertices released by the sample at (in_row, in_col), in emission order.
   always_comb begin
      em_new[0] = (in_row_ff != '0) && (in_col_ff != '0);
      em_new[1] = (in_row_ff != '0) && (in_col_ff == smax);
      em_new[2] = (in_row_ff == smax) && (in_col_ff != '0);
      em_new[3] = (in_row_ff == smax) && (in_col_ff == smax);
   end

   // Current vertex: lowest pending emission.
   always_comb begin
      em_low = em_ff & (~em_ff + 4'd1);
      z_is_r = em_low[2] || em_low[3];
      vz     = z_is_r ? r_ff : r_ff - CW'(1);
      vx     = (em_low[1] || em_low[3]) ? smax : c_ff - CW'(1);
      // line holding row z-1
      ln0    = z_is_r ? add_mod3(line_ff, 2'd2) : add_mod3(line_ff, 2'd1);
      fline  = add_mod3(ln0, fr_ff);
      csum   = {1'b0, vx} + (CW + 1)'(fc_ff);
      if (csum == '0) begin
         fcol = '0;
      end else if (32'(csum) - 1 >= MAX_GRID) begin
         fcol = CW'(32'(csum) - 1 - MAX_GRID);
      end else begin
         fcol = CW'(csum - (CW + 1)'(1));
      end
      tri_en[0] = (vz != '0) && (vx != '0);
      tri_en[1] = (vz != '0) && (vx != smax);
      tri_en[2] = tri_en[1];
      tri_en[3] = (vz != smax) && (vx != smax);
      tri_en[4] = (vz != smax) && (vx != '0);
      tri_en[5] = tri_en[4];
   end

   // Address of a line and column in the shared store.
   always_comb begin
      case (in_line_ff)
         2'd1:    waddr = AW'(MAX_GRID) + AW'(in_col_ff);
         2'd2:    waddr = AW'(2 * MAX_GRID) + AW'(in_col_ff);
         default: waddr = AW'(in_col_ff);
      endcase
      case (fline)
         2'd1:    raddr = AW'(MAX_GRID) + AW'(fcol);
         2'd2:    raddr = AW'(2 * MAX_GRID) + AW'(fcol);
         default: raddr = AW'(fcol);
      endcase
      rd_en = (st_ff == T_FETCH) && (fcnt_ff < 4'd9);
   end

   // Triangle corners in the 3x3 window (row-major, centre is the vertex).
   always_comb begin
      case (tri_ff)
         3'd0:    begin tp = hs_ff[3]; tq = hs_ff[4]; tp2 = hs_ff[1]; tq2 = hs_ff[4]; end
         3'd1:    begin tp = hs_ff[1]; tq = hs_ff[2]; tp2 = hs_ff[1]; tq2 = hs_ff[4]; end
         3'd2:    begin tp = hs_ff[4]; tq = hs_ff[5]; tp2 = hs_ff[2]; tq2 = hs_ff[5]; end
         3'd3:    begin tp = hs_ff[4]; tq = hs_ff[5]; tp2 = hs_ff[4]; tq2 = hs_ff[7]; end
         3'd4:    begin tp = hs_ff[3]; tq = hs_ff[4]; tp2 = hs_ff[3]; tq2 = hs_ff[6]; end
         default: begin tp = hs_ff[6]; tq = hs_ff[7]; tp2 = hs_ff[4]; tq2 = hs_ff[7]; end
      endcase
      d1 = $signed({1'b0, tp}) - $signed({1'b0, tq});
      d2 = $signed({1'b0, tp2}) - $signed({1'b0, tq2});
      m1 = $signed({1'b0, eff_s}) * d1;
      m2 = $signed({1'b0, eff_s}) * d2;
      if (st_ff == T_VERT) begin
         u_vec = acc_ff;
      end else begin
         u_vec[0] = hvn_pkg::VEC_W'(m1);
         u_vec[1] = hvn_pkg::VEC_W'($signed({1'b0, hvn_pkg::Y_RAW}));
         u_vec[2] = hvn_pkg::VEC_W'(m2);
      end
      u_ctl.start     = ((st_ff == T_TRI) && tri_en[tri_ff]) || (st_ff == T_VERT);
      u_ctl.vert_mode = (st_ff == T_VERT);
      for (int i = 0; i < 3; i++) begin
         if (u_res[i] > hvn_pkg::RES_W'(LIM)) begin
            sat[i] = hvn_pkg::RES_W'(LIM);
         end else if (u_res[i] < -hvn_pkg::RES_W'(LIM)) begin
            sat[i] = -hvn_pkg::RES_W'(LIM);
         end else begin
            sat[i] = u_res[i];
         end
      end
   end

   hvn_unitize #(
      .VERT_BITS (NORMAL_FRAC_BITS)
   ) u_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (u_ctl),
      .vec   (u_vec),
      .done  (u_done),
      .res   (u_res)
   );

   assign load = (st_ff == T_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      st_in      = st_ff;
      grid_in    = grid_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_line_in = in_line_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      line_in    = line_ff;
      em_in      = em_ff;
      fcnt_in    = fcnt_ff;
      fr_in      = fr_ff;
      fc_in      = fc_ff;
      tri_in     = tri_ff;
      acc_in     = acc_ff;
      nrm_in     = nrm_ff;
      case (st_ff)
         T_IDLE: begin
            if (accept) begin
               r_in    = in_row_ff;
               c_in    = in_col_ff;
               line_in = in_line_ff;
               em_in   = em_new;
               fcnt_in = '0;
               fr_in   = '0;
               fc_in   = '0;
               // advance the raster position, wrapping at the map end
               if (in_col_ff == smax) begin
                  in_col_in = '0;
                  if (in_row_ff == smax) begin
                     in_row_in  = '0;
                     in_line_in = 2'd0;
                  end else begin
                     in_row_in  = in_row_ff + CW'(1);
                     in_line_in = add_mod3(in_line_ff, 2'd1);
                  end
               end else begin
                  in_col_in = in_col_ff + CW'(1);
               end
               if (em_new != '0) st_in = T_FETCH;
            end
         end
         T_FETCH: begin
            fcnt_in = fcnt_ff + 4'd1;
            if (rd_en) begin
               if (fc_ff == 2'd2) begin
                  fc_in = '0;
                  fr_in = fr_ff + 2'd1;
               end else begin
                  fc_in = fc_ff + 2'd1;
               end
            end
            if (fcnt_ff == 4'd9) begin
               tri_in = '0;
               for (int i = 0; i < 3; i++) acc_in[i] = '0;
               st_in = T_TRI;
            end
         end
         T_TRI: begin
            if (tri_en[tri_ff]) begin
               st_in = T_TWAIT;
            end else if (tri_ff == 3'd5) begin
               st_in = T_VERT;
            end else begin
               tri_in = tri_ff + 3'd1;
            end
         end
         T_TWAIT: begin
            if (u_done) begin
               for (int i = 0; i < 3; i++) acc_in[i] = acc_ff[i] + hvn_pkg::VEC_W'(u_res[i]);
               if (tri_ff == 3'd5) begin
                  st_in = T_VERT;
               end else begin
                  tri_in = tri_ff + 3'd1;
                  st_in  = T_TRI;
               end
            end
         end
         T_VERT: st_in = T_VWAIT;
         T_VWAIT: begin
            if (u_done) begin
               nrm_in = sat;
               st_in  = T_OUT;
            end
         end
         T_OUT: begin
            if (load) begin
               em_in   = em_ff & ~em_low;
               fcnt_in = '0;
               fr_in   = '0;
               fc_in   = '0;
               st_in   = ((em_ff & ~em_low) != '0) ? T_FETCH : T_IDLE;
            end
         end
         default: st_in = T_IDLE;
      endcase
      // a register write restarts the map
      if (csr_wr_en) begin
         grid_in    = csr_wr_data;
         in_row_in  = '0;
         in_col_in  = '0;
         in_line_in = 2'd0;
      end
   end

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         grid_ff      <= hvn_pkg::GRID_RESET;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_line_ff   <= 2'd0;
         em_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         grid_ff      <= grid_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_line_ff   <= in_line_in;
         em_ff        <= em_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff    <= r_in;
      c_ff    <= c_in;
      line_ff <= line_in;
      fcnt_ff <= fcnt_in;
      fr_ff   <= fr_in;
      fc_ff   <= fc_in;
      tri_ff  <= tri_in;
      acc_ff  <= acc_in;
      nrm_ff  <= nrm_in;
      // shift the fetched window in, a byte at a time, from the registered read data
      if (st_ff == T_FETCH && fcnt_ff != 4'd0) begin
         for (int k = 0; k < 8; k++) hs_ff[k] <= hs_ff[k+1];
         hs_ff[8] <= rd_data_ff;
      end
      if (load) begin
         row_ff  <= hvn_pkg::POS_W'(vz);
         col_ff  <= hvn_pkg::POS_W'(vx);
         hgt_ff  <= hs_ff[4];
         nx_ff   <= nrm_ff[0][NORMAL_FRAC_BITS:0];
         ny_ff   <= nrm_ff[1][hvn_pkg::RES_W-1] ? '0 : nrm_ff[1][NORMAL_FRAC_BITS-1:0];
         nz_ff   <= nrm_ff[2][NORMAL_FRAC_BITS:0];
         last_ff <= (vz == smax) && (vx == smax);
      end
   end

   // Line store: write on acceptance, registered read for the window fetch.
   always_ff @(posedge clock) begin
      if (accept) mem[waddr] <= req_height_sample;
      if (rd_en) rd_data_ff <= mem[raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_row    = row_ff;
   assign rsp_vertex_col    = col_ff;
   assign rsp_vertex_height = hgt_ff;
   assign rsp_normal_x      = $signed(nx_ff);
   assign rsp_normal_y      = ny_ff;
   assign rsp_normal_z      = $signed(nz_ff);
   assign rsp_last_vertex   = last_ff;

`ifndef ASSERT_OFF
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      (em_ff != '0) |-> req_stall)
      else $error("item accepted while vertices still pending");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      u_done |-> (st_ff == T_TWAIT || st_ff == T_VWAIT))
      else $error("normaliser finished outside a wait state");

   a_last_on_diagonal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_vertex) |-> (rsp_vertex_row == rsp_vertex_col))
      else $error("last vertex off the map corner");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (st_ff == T_OUT && rsp_valid && rsp_stall) |=> (st_ff == T_OUT))
      else $error("result moved on while output stage full");
`endif

endmodule

/* test/tb_heightmap_vertex_normal_stream.sv */
// Self-checking testbench for heightmap_vertex_normal_stream: height items in, vertex normals out.
// Depends on hvn_pkg and the block; holds its own fixed-point predictor of the vertex normals.
module tb_heightmap_vertex_normal_stream;

   localparam int GRID_MAX  = 1024;
   localparam int FRAC      = 15;
   localparam int TRI_FRAC  = 24;
   localparam int DRAIN_CYC = 40;

   typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_type;

   // one row of the directed table; flat rows carry typed-in normals
   typedef struct {
      row_kind_type                kind;
      logic [hvn_pkg::CFG_W-1:0]   value;
      logic                        flat;
   } dir_row_type;

   typedef struct {
      logic [hvn_pkg::POS_W-1:0]  row;
      logic [hvn_pkg::POS_W-1:0]  col;
      logic [hvn_pkg::H_W-1:0]    height;
      logic signed [FRAC:0]       nx;
      logic [FRAC-1:0]            ny;
      logic signed [FRAC:0]       nz;
      logic                       last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [hvn_pkg::CFG_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [hvn_pkg::H_W-1:0] req_height_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [hvn_pkg::POS_W-1:0] rsp_vertex_row, rsp_vertex_col;
   logic [hvn_pkg::H_W-1:0] rsp_vertex_height;
   logic signed [FRAC:0] rsp_normal_x, rsp_normal_z;
   logic [FRAC-1:0] rsp_normal_y;
   logic rsp_last_vertex;

   heightmap_vertex_normal_stream u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_height_sample(req_height_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_vertex_row(rsp_vertex_row), .rsp_vertex_col(rsp_vertex_col),
      .rsp_vertex_height(rsp_vertex_height),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z),
      .rsp_last_vertex(rsp_last_vertex)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: three height lines, next sample position, grid register
   logic [7:0]  line_store [3*GRID_MAX];
   int unsigned at_row, at_col;
   logic [hvn_pkg::CFG_W-1:0] grid_reg;

   vertex_type pending_vertices[$];
   int fail_count = 0;
   int items_sent = 0;
   int vertices_seen = 0;
   int maps_done = 0;
   bit quiet = 1'b0;       // no idling on either side
   bit flat_row = 1'b0;    // current item belongs to a flat directed row

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // scale a vector to unit length with 'bits' fraction bits, round half up on magnitude
   task automatic unit_vec(input longint vx, input longint vy, input longint vz,
                           input int bits, output longint ox, output longint oy,
                           output longint oz);
      longint v[3];
      longint o[3];
      longint unsigned m[3];
      longint unsigned sq, len, q;
      int g;
      v[0] = vx; v[1] = vy; v[2] = vz;
      sq = 0;
      g = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
         sq = sq + m[i] * m[i];
      end
      if (sq == 0) begin
         ox = 0; oy = 0; oz = 0;
      end else begin
         while (sq < (64'd1 << 58)) begin
            sq = sq << 2;
            g++;
         end
         len = int_sqrt(sq);
         for (int i = 0; i < 3; i++) begin
            q = (((m[i] << g) << bits) + len / 2) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
         end
         ox = o[0]; oy = o[1]; oz = o[2];
      end
   endtask

   function automatic longint height_at(input int unsigned r, input int unsigned c);
      return longint'(line_store[(r % 3) * GRID_MAX + (c % GRID_MAX)]);
   endfunction

   // add the unit normals of the upper (A,D,B) and/or lower (C,B,D) triangle of a cell
   task automatic add_cell(input int unsigned z, input int unsigned x, input longint s,
                           input bit upper, input bit lower, inout longint acc[3]);
      longint a, b, c, d, ux, uy, uz;
      a = height_at(z, x);
      b = height_at(z, x + 1);
      c = height_at(z + 1, x + 1);
      d = height_at(z + 1, x);
      if (upper) begin
         unit_vec(s * (a - b), 255, s * (a - d), TRI_FRAC, ux, uy, uz);
         acc[0] += ux; acc[1] += uy; acc[2] += uz;
      end
      if (lower) begin
         unit_vec(s * (d - c), 255, s * (b - c), TRI_FRAC, ux, uy, uz);
         acc[0] += ux; acc[1] += uy; acc[2] += uz;
      end
   endtask

   task automatic queue_vertex(input int unsigned z, input int unsigned x, input int unsigned s);
      longint acc[3];
      longint n[3];
      longint lim;
      vertex_type vx;
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      lim = (64'd1 << FRAC) - 1;
      if (z > 0 && x > 0)         add_cell(z - 1, x - 1, s, 1'b0, 1'b1, acc);
      if (z > 0 && x < s - 1)     add_cell(z - 1, x,     s, 1'b1, 1'b1, acc);
      if (z < s - 1 && x < s - 1) add_cell(z,     x,     s, 1'b1, 1'b0, acc);
      if (z < s - 1 && x > 0)     add_cell(z,     x - 1, s, 1'b1, 1'b1, acc);
      unit_vec(acc[0], acc[1], acc[2], FRAC, n[0], n[1], n[2]);
      // saturate a full unit magnitude to the largest Q1.15 value
      for (int i = 0; i < 3; i++) begin
         if (n[i] > lim) n[i] = lim;
         if (n[i] < -lim) n[i] = -lim;
      end
      vx.row    = z[hvn_pkg::POS_W-1:0];
      vx.col    = x[hvn_pkg::POS_W-1:0];
      vx.height = line_store[(z % 3) * GRID_MAX + x];
      vx.nx     = n[0][FRAC:0];
      vx.ny     = n[1] < 0 ? '0 : n[1][FRAC-1:0];
      vx.nz     = n[2][FRAC:0];
      vx.last   = (z == s - 1 && x == s - 1);
      if (flat_row) begin
         // a flat patch points straight up: typed in rather than predicted
         vx.nx = '0;
         vx.ny = 15'd32767;
         vx.nz = '0;
      end
      pending_vertices = {pending_vertices, vx};
   endtask

   // advance the predictor by one accepted height item
   task automatic accept_height(input logic [7:0] h);
      int unsigned s, r, c;
      s = grid_reg < 2 ? 2 : (grid_reg > GRID_MAX ? GRID_MAX : grid_reg);
      if (at_row >= s || at_col >= s) begin
         at_row = 0;
         at_col = 0;
      end
      r = at_row;
      c = at_col;
      line_store[(r % 3) * GRID_MAX + c] = h;
      if (r >= 1 && c >= 1)         queue_vertex(r - 1, c - 1, s);
      if (r >= 1 && c == s - 1)     queue_vertex(r - 1, s - 1, s);
      if (r == s - 1 && c >= 1)     queue_vertex(r, c - 1, s);
      if (r == s - 1 && c == s - 1) begin
         queue_vertex(r, s - 1, s);
         maps_done++;
      end
      c++;
      if (c >= s) begin
         c = 0;
         r++;
         if (r >= s) r = 0;
      end
      at_row = r;
      at_col = c;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      vertex_type want;
      if (!reset) begin
         if (req_valid && !req_stall) accept_height(req_height_sample);
         if (rsp_valid && !rsp_stall) begin
            vertices_seen++;
            if (pending_vertices.size() == 0) begin
               $error("vertex (%0d,%0d) arrived with nothing expected",
                      rsp_vertex_row, rsp_vertex_col);
               fail_count++;
            end else begin
               want = pending_vertices.pop_front();
               check_field("vertex_row", want.row, rsp_vertex_row);
               check_field("vertex_col", want.col, rsp_vertex_col);
               check_field("vertex_height", want.height, rsp_vertex_height);
               check_field("normal_x", want.nx, rsp_normal_x);
               check_field("normal_y", want.ny, rsp_normal_y);
               check_field("normal_z", want.nz, rsp_normal_z);
               check_field("last_vertex", want.last, rsp_last_vertex);
            end
         end
      end
   end

   // receiver: stall in random bursts, none once quiet
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet && !reset && $urandom_range(5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // hold the item until accepted; optionally idle beforehand
   task automatic send_height(input logic [7:0] h);
      if (!quiet && $urandom_range(7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_height_sample <= h;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid and wait until every expected vertex has come, then let the block settle
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
   endtask

   task automatic write_grid(input logic [hvn_pkg::CFG_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      grid_reg = value;
      at_row   = 0;
      at_col   = 0;
   endtask

   function automatic logic [7:0] pick_height();
      case ($urandom_range(3))
         0:       return $urandom_range(1) ? 8'hFF : 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   dir_row_type directed [] = '{
      // flat 2x2 map: four vertices, all straight up, last one flagged
      '{ROW_CFG, 11'd2, 1'b0},
      '{ROW_SAMPLE, 11'd100, 1'b1}, '{ROW_SAMPLE, 11'd100, 1'b1},
      '{ROW_SAMPLE, 11'd100, 1'b1}, '{ROW_SAMPLE, 11'd100, 1'b1},
      // steepest slopes, then map end wraps into a second map
      '{ROW_SAMPLE, 11'd0, 1'b0},   '{ROW_SAMPLE, 11'd255, 1'b0},
      '{ROW_SAMPLE, 11'd255, 1'b0}, '{ROW_SAMPLE, 11'd0, 1'b0},
      // register below range acts as 2
      '{ROW_CFG, 11'd0, 1'b0},
      '{ROW_SAMPLE, 11'd255, 1'b0}, '{ROW_SAMPLE, 11'd0, 1'b0},
      '{ROW_SAMPLE, 11'd0, 1'b0},   '{ROW_SAMPLE, 11'd255, 1'b0},
      '{ROW_CFG, 11'd1, 1'b0},
      '{ROW_SAMPLE, 11'd7, 1'b0},   '{ROW_SAMPLE, 11'd200, 1'b0},
      // above range acts as the largest grid: row 0 alone emits nothing
      '{ROW_CFG, 11'd2047, 1'b0},
      '{ROW_SAMPLE, 11'd1, 1'b0},   '{ROW_SAMPLE, 11'd254, 1'b0},
      '{ROW_CFG, 11'd1024, 1'b0},
      '{ROW_SAMPLE, 11'd128, 1'b0}, '{ROW_SAMPLE, 11'd127, 1'b0},
      '{ROW_CFG, 11'd3, 1'b0}
   };

   initial begin
      int unsigned s, n;
      grid_reg = hvn_pkg::GRID_RESET;
      at_row   = 0;
      at_col   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CFG) begin
            write_grid(directed[i].value);
         end else begin
            flat_row = directed[i].flat;
            send_height(directed[i].value[7:0]);
         end
      end
      drain();
      flat_row = 1'b0;
      // pause the sender until the block has emptied at least once in a map too
      for (int k = 0; k < 4; k++) send_height(pick_height());
      drain();

      // random maps: mostly complete small grids, sometimes cut short or run past the end
      while (items_sent < 300) begin
         if (items_sent > 250) quiet = 1'b1;
         s = $urandom_range(9) == 0 ? $urandom_range(9, 12) : $urandom_range(2, 6);
         write_grid(s[hvn_pkg::CFG_W-1:0]);
         case ($urandom_range(5))
            0:       n = $urandom_range(1, s * s - 1);
            1:       n = s * s + $urandom_range(1, s * s);
            default: n = s * s;
         endcase
         // keep the total close to the planned item count
         if (n > 320 - items_sent) n = 320 - items_sent;
         for (int k = 0; k < n; k++) send_height(pick_height());
      end

      drain();
      $display("Covered %0d height items, %0d vertices, %0d complete maps,",
               items_sent, vertices_seen, maps_done);
      $display("grids of 2 to 12 plus out-of-range and largest settings, with idling both sides.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // generous bound on the slowest correct run
   initial begin
      #60_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
